/* rtl/core/bbd_pkg.sv */
// Shared types and constants of the bilinear Bayer demosaic block
package bbd_pkg;

  // field and register widths
  localparam int SAMPLE_W  = 8;
  localparam int DIM_W     = 12;
  localparam int CFG_IDX_W = 2;

  // default frame size limits
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  // register reset values
  localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // input command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT,
    ST_CALC,
    ST_EMIT
  } ctl_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic shift;
    logic zero_in;
    logic calc;
    logic emit;
    logic restart;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last_in;
    logic shift_hit;
    logic frame_end;
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/core/bbd_ctrl.sv */
// Sequencer of the demosaic block: item acceptance, line-store shifts, pixel emission
module bbd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_cmd_i,
  input  logic               cfg_hit_i,
  input  bbd_pkg::dp_status_t status_i,
  output logic               in_stall_o,
  output bbd_pkg::dp_cmd_t    cmd_o
);

  bbd_pkg::ctl_state_e state_q, state_d;
  logic flushing_q, flushing_d;
  logic second_q, second_d;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bbd_pkg::ST_IDLE;
      flushing_q <= 1'b0;
      second_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      flushing_q <= flushing_d;
      second_q   <= second_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    flushing_d = flushing_q;
    second_d   = second_q;
    cmd_o      = '0;
    case (state_q)
      bbd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          // a drain word while the frame is still arriving is dropped
          if (flushing_q || (in_cmd_i != bbd_pkg::CMD_DRAIN)) begin
            state_d  = bbd_pkg::ST_READ;
            second_d = 1'b0;
          end
        end
      end
      bbd_pkg::ST_READ: begin
        state_d = bbd_pkg::ST_SHIFT;
      end
      bbd_pkg::ST_SHIFT: begin
        cmd_o.shift   = 1'b1;
        cmd_o.zero_in = flushing_q;
        if (!flushing_q && status_i.last_in) begin
          flushing_d = 1'b1;
        end
        if (status_i.shift_hit) begin
          state_d = bbd_pkg::ST_CALC;
        end else if (flushing_q && !second_q) begin
          // single-row frame: the first flush word shifts twice
          second_d = 1'b1;
          state_d  = bbd_pkg::ST_READ;
        end else begin
          state_d = bbd_pkg::ST_IDLE;
        end
      end
      bbd_pkg::ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = bbd_pkg::ST_EMIT;
      end
      bbd_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.frame_end) begin
            flushing_d = 1'b0;
          end
          state_d = bbd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bbd_pkg::ST_IDLE;
      end
    endcase
    // register write restarts the frame
    if (cfg_hit_i) begin
      cmd_o.restart = 1'b1;
      flushing_d    = 1'b0;
      second_d      = 1'b0;
      state_d       = bbd_pkg::ST_IDLE;
    end
  end

  assign in_stall_o = (state_q != bbd_pkg::ST_IDLE);

endmodule

/* rtl/core/bbd_datapath.sv */
// Datapath of the demosaic block: line stores, 3x3 window, positions, interpolation
module bbd_datapath #(
  parameter int MAX_WIDTH  = bbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bbd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bbd_pkg::dp_cmd_t                cmd_i,
  output bbd_pkg::dp_status_t             status_o,
  input  logic                           cfg_we_i,
  input  logic [bbd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bbd_pkg::DIM_W-1:0]      cfg_data_i,
  input  logic [bbd_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic [bbd_pkg::SAMPLE_W-1:0]   red_o,
  output logic [bbd_pkg::SAMPLE_W-1:0]   green_o,
  output logic [bbd_pkg::SAMPLE_W-1:0]   blue_o,
  output logic                           frame_end_o
);

  localparam int SW   = bbd_pkg::SAMPLE_W;
  localparam int CAW  = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 2);
  localparam int RAW  = $clog2(MAX_HEIGHT);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int WEXT = (WW > bbd_pkg::DIM_W) ? WW : bbd_pkg::DIM_W;
  localparam int HEXT = (HW > bbd_pkg::DIM_W) ? HW : bbd_pkg::DIM_W;

  typedef struct packed {
    logic [9:0] sum;
    logic [2:0] cnt;
  } mean_t;

  // truncated mean of up to four samples; three uses a reciprocal multiply
  function automatic logic [SW-1:0] mean_div(input mean_t m);
    logic [19:0] prod;
    logic [SW-1:0] res;
    prod = 20'(m.sum) * 20'd683;
    case (m.cnt)
      3'd1:    res = m.sum[7:0];
      3'd2:    res = m.sum[8:1];
      3'd3:    res = prod[18:11];
      3'd4:    res = m.sum[9:2];
      default: res = '0;
    endcase
    return res;
  endfunction

  // configuration and position registers
  logic [bbd_pkg::DIM_W-1:0] width_q, width_d, height_q, height_d;
  logic [CAW-1:0] in_col_q, in_col_d, out_col_q, out_col_d, shift_col_q, shift_col_d;
  logic [RAW-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [WW-1:0]  shift_cnt_q, shift_cnt_d;
  logic           out_valid_q, out_valid_d;

  // payload registers
  logic [SW-1:0] sample_q;
  logic [SW-1:0] win_q [9];
  logic [SW-1:0] rd_top_q, rd_mid_q;
  logic [SW-1:0] red_q, green_q, blue_q;
  logic          fe_q, out_fe_q;
  mean_t         red_m_q, green_m_q, blue_m_q;

  // line stores: previous row and the row before it
  logic [SW-1:0] line_top_mem [MAX_WIDTH];
  logic [SW-1:0] line_mid_mem [MAX_WIDTH];

  // effective frame size, clamped to the supported range
  logic [WEXT-1:0] width_ext;
  logic [HEXT-1:0] height_ext;
  logic [WW-1:0]   eff_w;
  logic [HW-1:0]   eff_h;

  assign width_ext  = WEXT'(width_q);
  assign height_ext = HEXT'(height_q);

  always_comb begin
    if (width_ext == '0) begin
      eff_w = WW'(1);
    end else if (width_ext > WEXT'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_ext);
    end
    if (height_ext == '0) begin
      eff_h = HW'(1);
    end else if (height_ext > HEXT'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(height_ext);
    end
  end

  // position increments and wrap tests
  logic [WW-1:0] in_col_inc, out_col_inc, shift_col_inc;
  logic [HW-1:0] in_row_inc, out_row_inc;
  logic in_col_wrap, in_row_wrap, out_col_wrap, out_row_wrap, shift_col_wrap;

  assign in_col_inc     = WW'(in_col_q) + WW'(1);
  assign in_row_inc     = HW'(in_row_q) + HW'(1);
  assign out_col_inc    = WW'(out_col_q) + WW'(1);
  assign out_row_inc    = HW'(out_row_q) + HW'(1);
  assign shift_col_inc  = WW'(shift_col_q) + WW'(1);
  assign in_col_wrap    = (in_col_inc >= eff_w);
  assign in_row_wrap    = (in_row_inc >= eff_h);
  assign out_col_wrap   = (out_col_inc >= eff_w);
  assign out_row_wrap   = (out_row_inc >= eff_h);
  assign shift_col_wrap = (shift_col_inc >= eff_w);

  // value shifted into the bottom row of the window
  logic [SW-1:0] shift_val;
  assign shift_val = cmd_i.zero_in ? '0 : sample_q;

  // line store access: registered read at the shift column
  always_ff @(posedge clk_i) begin
    rd_top_q <= line_top_mem[shift_col_q];
    rd_mid_q <= line_mid_mem[shift_col_q];
    if (cmd_i.shift) begin
      line_top_mem[shift_col_q] <= rd_mid_q;
      line_mid_mem[shift_col_q] <= shift_val;
    end
  end

  // next values of control registers
  always_comb begin
    width_d     = width_q;
    height_d    = height_q;
    in_col_d    = in_col_q;
    in_row_d    = in_row_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    shift_col_d = shift_col_q;
    shift_cnt_d = shift_cnt_q;
    out_valid_d = out_valid_q & out_stall_i;
    if (cfg_we_i && (cfg_index_i == bbd_pkg::CFG_IMAGE_WIDTH)) begin
      width_d = cfg_data_i;
    end
    if (cfg_we_i && (cfg_index_i == bbd_pkg::CFG_IMAGE_HEIGHT)) begin
      height_d = cfg_data_i;
    end
    if (cmd_i.shift) begin
      shift_col_d = shift_col_wrap ? '0 : CAW'(shift_col_inc);
      if (!status_o.shift_hit) begin
        shift_cnt_d = shift_cnt_q + WW'(1);
      end
      if (!cmd_i.zero_in) begin
        if (in_col_wrap) begin
          in_col_d = '0;
          in_row_d = in_row_wrap ? '0 : RAW'(in_row_inc);
        end else begin
          in_col_d = CAW'(in_col_inc);
        end
      end
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      if (out_col_wrap) begin
        out_col_d = '0;
        out_row_d = out_row_wrap ? '0 : RAW'(out_row_inc);
      end else begin
        out_col_d = CAW'(out_col_inc);
      end
      if (fe_q) begin
        shift_cnt_d = '0;
        shift_col_d = '0;
      end
    end
    if (cmd_i.restart) begin
      in_col_d    = '0;
      in_row_d    = '0;
      out_col_d   = '0;
      out_row_d   = '0;
      shift_col_d = '0;
      shift_cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= bbd_pkg::RESET_WIDTH;
      height_q    <= bbd_pkg::RESET_HEIGHT;
      in_col_q    <= '0;
      in_row_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      shift_col_q <= '0;
      shift_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      width_q     <= width_d;
      height_q    <= height_d;
      in_col_q    <= in_col_d;
      in_row_q    <= in_row_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
      shift_col_q <= shift_col_d;
      shift_cnt_q <= shift_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // neighbor masks at the frame edges
  logic up, dn, lf, rt;
  assign up = (out_row_q != '0);
  assign dn = (out_row_inc < eff_h);
  assign lf = (out_col_q != '0);
  assign rt = (out_col_inc < eff_w);

  // candidate sums and counts
  mean_t vert_m, horz_m, sides_m, corner_m, ctr_m;
  always_comb begin
    vert_m.sum   = (up ? 10'(win_q[1]) : 10'd0) + (dn ? 10'(win_q[7]) : 10'd0);
    vert_m.cnt   = 3'(up) + 3'(dn);
    horz_m.sum   = (lf ? 10'(win_q[3]) : 10'd0) + (rt ? 10'(win_q[5]) : 10'd0);
    horz_m.cnt   = 3'(lf) + 3'(rt);
    sides_m.sum  = vert_m.sum + horz_m.sum;
    sides_m.cnt  = vert_m.cnt + horz_m.cnt;
    corner_m.sum = ((up && lf) ? 10'(win_q[0]) : 10'd0)
                 + ((up && rt) ? 10'(win_q[2]) : 10'd0)
                 + ((dn && lf) ? 10'(win_q[6]) : 10'd0)
                 + ((dn && rt) ? 10'(win_q[8]) : 10'd0);
    corner_m.cnt = 3'(up && lf) + 3'(up && rt) + 3'(dn && lf) + 3'(dn && rt);
    ctr_m.sum    = 10'(win_q[4]);
    ctr_m.cnt    = 3'd1;
  end

  // window shift, channel selection and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sample_i;
    end
    if (cmd_i.shift) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= rd_top_q;
      win_q[3] <= win_q[4];
      win_q[4] <= win_q[5];
      win_q[5] <= rd_mid_q;
      win_q[6] <= win_q[7];
      win_q[7] <= win_q[8];
      win_q[8] <= shift_val;
    end
    if (cmd_i.calc) begin
      fe_q <= out_row_wrap && out_col_wrap;
      case ({out_row_q[0], out_col_q[0]})
        2'b00: begin
          red_m_q   <= vert_m;
          green_m_q <= ctr_m;
          blue_m_q  <= horz_m;
        end
        2'b01: begin
          red_m_q   <= corner_m;
          green_m_q <= sides_m;
          blue_m_q  <= ctr_m;
        end
        2'b10: begin
          red_m_q   <= ctr_m;
          green_m_q <= sides_m;
          blue_m_q  <= corner_m;
        end
        default: begin
          red_m_q   <= horz_m;
          green_m_q <= ctr_m;
          blue_m_q  <= vert_m;
        end
      endcase
    end
    if (cmd_i.emit) begin
      red_q    <= mean_div(red_m_q);
      green_q  <= mean_div(green_m_q);
      blue_q   <= mean_div(blue_m_q);
      out_fe_q <= fe_q;
    end
  end

  // status back to the sequencer
  assign status_o.last_in   = in_col_wrap && in_row_wrap;
  assign status_o.shift_hit = (shift_cnt_q >= (eff_w + WW'(1)));
  assign status_o.frame_end = fe_q;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign frame_end_o = out_fe_q;

endmodule

/* rtl/core/bayer_bilinear_demosaic_unit.sv */
// Top level of the bilinear Bayer demosaic block (GBRG pattern)
//
// Raw 8-bit samples arrive in raster order (even rows G,B; odd rows R,G) and one
// RGB word leaves per pixel, lagging the input by one row plus one pixel; drain
// words (cmd 1) after the last sample of a frame flush the pending pixels, and
// frame_end marks the frame's last pixel. A word that emits nothing passes the states
// accept, line-store read and window shift, and a word that emits a pixel also passes
// calc and emit and waits while the output side stalls, since each shift waits on
// the registered read port of the two line stores and interpolation takes a sum
// stage and a divide stage. The first drain word of a single-row frame shifts
// twice (shift, read, shift). A drain word while a frame is still arriving is
// dropped. Writing image_width or image_height restarts the frame;
// write only while the block is idle. Sizes are clamped to 1..MAX_WIDTH and
// 1..MAX_HEIGHT.
module bayer_bilinear_demosaic_unit #(
  parameter int MAX_WIDTH  = bbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bbd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           cmd_i,
  input  logic [bbd_pkg::SAMPLE_W-1:0]   sample_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [bbd_pkg::SAMPLE_W-1:0]   red_o,
  output logic [bbd_pkg::SAMPLE_W-1:0]   green_o,
  output logic [bbd_pkg::SAMPLE_W-1:0]   blue_o,
  output logic                           frame_end_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bbd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bbd_pkg::DIM_W-1:0]      cfg_data_i
);

  bbd_pkg::dp_cmd_t    dp_cmd;
  bbd_pkg::dp_status_t dp_status;
  logic cfg_we;
  logic cfg_hit;

  // register writes are always taken; a known index restarts the frame
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_hit     = cfg_we && ((cfg_index_i == bbd_pkg::CFG_IMAGE_WIDTH) ||
                                  (cfg_index_i == bbd_pkg::CFG_IMAGE_HEIGHT));

  // sequencer
  bbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (cmd_i),
    .cfg_hit_i  (cfg_hit),
    .status_i   (dp_status),
    .in_stall_o (in_stall_o),
    .cmd_o      (dp_cmd)
  );

  // line stores, window and interpolation
  bbd_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (sample_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .frame_end_o (frame_end_o)
  );

endmodule
